// File: rtl/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
package spq_pkg;

    localparam int VAL_W     = 32;
    localparam int COUNT_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 8;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

endpackage

// File: rtl/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic signed [spq_pkg::VAL_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface spq_rsp_if;
    logic                               valid;
    logic                               ready;
    spq_pkg::status_t                   status;
    logic signed [spq_pkg::VAL_W-1:0]   removed_value;
    logic        [spq_pkg::COUNT_W-1:0] count;

    modport source (output valid, output status, output removed_value, output count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input count,
                    output ready);
endinterface

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue: top level with the insert/delete sequencer.
//
// Usage: requests arrive on req (mode 0 insert value, mode 1 delete the
// smallest entry); every request gives exactly one response on rsp with
// status (ok, full, empty), the removed value (zero unless a delete
// succeeded) and the entry count after the request. Entries sit in
// ascending order in a single-port-write RAM; one signed comparator and
// the RAM port are reused for every element the request touches.
// Sequencing: a refused request (full or empty) or an insert into an empty
// queue is answered straight from idle. Otherwise an insert walks from the
// tail toward the head, moving each entry not below the new value up, and
// a delete walks from the head, moving each entry down. Each element step
// is a RAM read then a compare/move; an insert at the head ends in a write.
// Throughput: one request at a time; req.ready is low while a request is
// in progress and while a response is held and not taken.
// Reset: the queue is empty and no response is pending; RAM contents are
// not cleared, since only live entries are ever read.
// Stall: the response is held in an output register until rsp.ready.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_WR0
    } state_t;

    state_t                           state_reg;
    logic                             op_reg;
    logic signed [spq_pkg::VAL_W-1:0] val_reg;
    logic        [AW-1:0]             idx_reg;
    logic        [CW-1:0]             held_reg;
    logic signed [spq_pkg::VAL_W-1:0] removed_reg;

    logic                               out_valid_reg;
    spq_pkg::status_t                   status_reg;
    logic signed [spq_pkg::VAL_W-1:0]   rmv_out_reg;
    logic        [spq_pkg::COUNT_W-1:0] count_reg;

    logic                             req_fire;
    logic                             quick_rsp;
    logic                             ram_we;
    logic        [AW-1:0]             ram_waddr;
    logic        [spq_pkg::VAL_W-1:0] ram_wdata;
    logic        [spq_pkg::VAL_W-1:0] ram_rdata;
    logic signed [spq_pkg::VAL_W-1:0] rd_val;
    logic                             val_le;
    logic                             idx_last;
    logic                             is_full;
    logic                             is_empty;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    // request answered straight from idle
    assign quick_rsp = req_fire && ((req.mode == spq_pkg::MODE_INSERT) ?
                                    (is_full || is_empty) : is_empty);

    assign rd_val   = $signed(ram_rdata);
    // shared comparator: new value goes ahead of equal entries
    assign val_le   = (val_reg <= rd_val);
    assign idx_last = ((CW'(idx_reg) + CW'(1)) == held_reg);
    assign is_full  = (held_reg == CW'(DEPTH));
    assign is_empty = (held_reg == '0);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = val_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && req.mode == spq_pkg::MODE_INSERT && is_empty)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = req.value;
                end
            end
            S_CMP:
            begin
                if (op_reg == spq_pkg::MODE_INSERT)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx_reg + AW'(1));
                    ram_wdata = val_le ? ram_rdata : val_reg;
                end
                else if (idx_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx_reg - AW'(1));
                    ram_wdata = ram_rdata;
                end
            end
            S_WR0:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    spq_ram #(
        .WIDTH (spq_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= spq_pkg::MODE_INSERT;
            idx_reg       <= '0;
            val_reg       <= '0;
            removed_reg   <= '0;
            status_reg    <= spq_pkg::ST_OK;
            rmv_out_reg   <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !quick_rsp)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg  <= req.mode;
                        val_reg <= req.value;
                        if (req.mode == spq_pkg::MODE_INSERT)
                        begin
                            if (is_full)
                            begin
                                out_valid_reg <= 1'b1;
                                status_reg    <= spq_pkg::ST_FULL;
                                rmv_out_reg   <= '0;
                                count_reg     <= spq_pkg::COUNT_W'(held_reg);
                            end
                            else if (is_empty)
                            begin
                                held_reg      <= CW'(1);
                                out_valid_reg <= 1'b1;
                                status_reg    <= spq_pkg::ST_OK;
                                rmv_out_reg   <= '0;
                                count_reg     <= spq_pkg::COUNT_W'(1);
                            end
                            else
                            begin
                                // walk from the tail toward the head
                                idx_reg   <= AW'(held_reg - CW'(1));
                                state_reg <= S_RD;
                            end
                        end
                        else
                        begin
                            if (is_empty)
                            begin
                                out_valid_reg <= 1'b1;
                                status_reg    <= spq_pkg::ST_EMPTY;
                                rmv_out_reg   <= '0;
                                count_reg     <= '0;
                            end
                            else
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (op_reg == spq_pkg::MODE_INSERT)
                    begin
                        if (!val_le)
                        begin
                            held_reg      <= CW'(held_reg + CW'(1));
                            out_valid_reg <= 1'b1;
                            status_reg    <= spq_pkg::ST_OK;
                            rmv_out_reg   <= '0;
                            count_reg     <= spq_pkg::COUNT_W'(held_reg + CW'(1));
                            state_reg     <= S_IDLE;
                        end
                        else if (idx_reg == '0)
                        begin
                            state_reg <= S_WR0;
                        end
                        else
                        begin
                            idx_reg   <= AW'(idx_reg - AW'(1));
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (idx_reg == '0)
                        begin
                            removed_reg <= rd_val;
                        end
                        if (idx_last)
                        begin
                            held_reg      <= CW'(held_reg - CW'(1));
                            out_valid_reg <= 1'b1;
                            status_reg    <= spq_pkg::ST_OK;
                            rmv_out_reg   <= (idx_reg == '0) ? rd_val : removed_reg;
                            count_reg     <= spq_pkg::COUNT_W'(held_reg - CW'(1));
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= AW'(idx_reg + AW'(1));
                            state_reg <= S_RD;
                        end
                    end
                end
                S_WR0:
                begin
                    held_reg      <= CW'(held_reg + CW'(1));
                    out_valid_reg <= 1'b1;
                    status_reg    <= spq_pkg::ST_OK;
                    rmv_out_reg   <= '0;
                    count_reg     <= spq_pkg::COUNT_W'(held_reg + CW'(1));
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = rmv_out_reg;
    assign rsp.count         = count_reg;

endmodule

// File: rtl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
    parameter int WIDTH = spq_pkg::VAL_W,
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/spq_chk.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_chk #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input spq_pkg::status_t                   rsp_status,
    input logic signed [spq_pkg::VAL_W-1:0]   rsp_removed_value,
    input logic        [spq_pkg::COUNT_W-1:0] rsp_count
);

    // a held response keeps its payload until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_removed_value) && $stable(rsp_count))
        else $error("response changed while stalled");

    // no request taken while an untaken response is waiting
    a_no_req_on_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid || rsp_ready)
        else $error("request accepted while response held");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == spq_pkg::ST_FULL |->
            rsp_removed_value == '0 && rsp_count == spq_pkg::COUNT_W'(DEPTH))
        else $error("full response with wrong value or count");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == spq_pkg::ST_EMPTY |->
            rsp_removed_value == '0 && rsp_count == '0)
        else $error("empty response with wrong value or count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> DEPTH > 15 || 32'(rsp_count) <= 32'(DEPTH))
        else $error("count above depth");

endmodule

bind sorted_priority_queue spq_chk #(
    .DEPTH (DEPTH)
) u_spq_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_removed_value (rsp.removed_value),
    .rsp_count         (rsp.count)
);

// File: sim/sorted_priority_queue_test.sv
// Self-checking testbench for the sorted priority queue, checked against a predictor.
module sorted_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = spq_pkg::DEPTH_DEF;
    localparam int VAL_W        = spq_pkg::VAL_W;
    localparam int COUNT_W      = spq_pkg::COUNT_W;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    typedef struct {
        logic                    mode;
        logic signed [VAL_W-1:0] value;
    } pq_request_t;

    typedef struct {
        spq_pkg::status_t        status;
        logic signed [VAL_W-1:0] removed;
        logic [COUNT_W-1:0]      count;
    } pq_response_t;

    logic clk;
    logic rst_n;

    spq_req_if req();
    spq_rsp_if rsp();

    sorted_priority_queue #(.DEPTH(DEPTH)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    pq_request_t             req_pending[$];
    pq_response_t            rsp_expected[$];
    logic signed [VAL_W-1:0] model_cells[DEPTH];
    int                      model_held;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   error_count;
    int   cycle_count;
    logic req_fired;
    logic hold_arm;
    logic hold_done;
    int   hold_left;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Predicts the response to one request and updates the sorted copy.
    function automatic pq_response_t predict_response(logic mode,
                                                      logic signed [VAL_W-1:0] value);
        pq_response_t res;
        int           pos;
        res.status  = spq_pkg::ST_OK;
        res.removed = '0;
        if (mode == spq_pkg::MODE_INSERT)
        begin
            if (model_held >= DEPTH)
                res.status = spq_pkg::ST_FULL;
            else
            begin
                // first cell >= value; cells are ascending so scanning down keeps the lowest
                pos = model_held;
                for (int i = model_held - 1; i >= 0; i--)
                    if (value <= model_cells[i])
                        pos = i;
                for (int i = model_held; i > pos; i--)
                    model_cells[i] = model_cells[i-1];
                model_cells[pos] = value;
                model_held++;
            end
        end
        else
        begin
            if (model_held == 0)
                res.status = spq_pkg::ST_EMPTY;
            else
            begin
                res.removed = model_cells[0];
                for (int i = 1; i < model_held; i++)
                    model_cells[i-1] = model_cells[i];
                model_held--;
            end
        end
        res.count = COUNT_W'(model_held);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic add_request(logic mode, logic signed [VAL_W-1:0] value);
        pq_request_t r;
        r.mode  = mode;
        r.value = value;
        req_pending.push_back(r);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(4))
            0: v = $signed(VAL_W'($urandom_range(6))) - 3;   // tight range, many ties
            1:
            begin
                case ($urandom_range(3))
                    0: v = {1'b0, {(VAL_W-1){1'b1}}};
                    1: v = {1'b1, {(VAL_W-1){1'b0}}};
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Bursts leaning toward insert, toward delete or balanced, so the queue swings between full and empty.
    task automatic add_random_requests(int n);
        int burst;
        int ins_pct;
        int left;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 14);
            case ($urandom_range(2))
                0: ins_pct = 85;
                1: ins_pct = 20;
                default: ins_pct = 50;
            endcase
            for (int i = 0; i < burst && left > 0; i++)
            begin
                if ($urandom_range(99) < ins_pct)
                    add_request(spq_pkg::MODE_INSERT, pick_value());
                else
                    add_request(spq_pkg::MODE_DELETE, $urandom);
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        while (req_pending.size() != 0 || rsp_expected.size() != 0)
            @(posedge clk);
    endtask

    // request side: accept, predict
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_fired <= 1'b0;
        else
        begin
            req_fired <= req.valid && req.ready;
            if (req.valid && req.ready)
            begin
                void'(req_pending.pop_front());
                rsp_expected.push_back(predict_response(req.mode, req.value));
            end
        end
    end

    // driver: valid stays up until the request is taken
    always @(negedge clk)
    begin
        if (rst_n && (!req.valid || req_fired))
        begin
            if (req_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req.valid <= 1'b1;
                req.mode  <= req_pending[0].mode;
                req.value <= req_pending[0].value;
            end
            else
                req.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off, started once
    always @(posedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        pq_response_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (rsp_expected.size() == 0)
                report_mismatch("unexpected response, count", rsp.count, -1);
            else
            begin
                want = rsp_expected.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.removed_value !== want.removed)
                    report_mismatch("removed_value", rsp.removed_value, want.removed);
                if (rsp.count !== want.count)
                    report_mismatch("count", rsp.count, want.count);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("sorted_priority_queue_test: errors");
            $finish;
        end
    end

    initial begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.mode      = spq_pkg::MODE_INSERT;
        req.value     = '0;
        rsp.ready     = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 62;
        error_count   = 0;
        cycle_count   = 0;
        hold_arm      = 1'b0;
        hold_done     = 1'b0;
        hold_left     = 0;
        model_held    = 0;
        foreach (model_cells[i])
            model_cells[i] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // delete from empty, fill with extremes and ties, insert into full, empty it again
        add_request(spq_pkg::MODE_DELETE, '0);
        add_request(spq_pkg::MODE_INSERT, {1'b0, {(VAL_W-1){1'b1}}});
        add_request(spq_pkg::MODE_INSERT, {1'b1, {(VAL_W-1){1'b0}}});
        add_request(spq_pkg::MODE_INSERT, '0);
        add_request(spq_pkg::MODE_INSERT, '1);
        add_request(spq_pkg::MODE_INSERT, 5);
        add_request(spq_pkg::MODE_INSERT, 5);
        add_request(spq_pkg::MODE_INSERT, 5);
        add_request(spq_pkg::MODE_INSERT, 1);
        add_request(spq_pkg::MODE_INSERT, 3);
        for (int i = 0; i < DEPTH; i++)
            add_request(spq_pkg::MODE_DELETE, '1);
        add_request(spq_pkg::MODE_DELETE, '0);
        add_random_requests(450);
        wait_drained();

        send_idle_pct = 62;
        recv_idle_pct = 21;
        add_random_requests(450);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_arm      = 1'b1;
        add_random_requests(480);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("sorted_priority_queue_test: clean");
        else
            $display("sorted_priority_queue_test: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_ram.sv
rtl/sorted_priority_queue.sv
rtl/spq_chk.sv
sim/sorted_priority_queue_test.sv
